// ===== design/vtf_pkg.sv =====
// Shared types, widths and codes for the visual target follow controller.
// No dependencies; every other design file refers to it by scoped names.
package vtf_pkg;

  // Field widths
  localparam int COORD_BITS    = 10;
  localparam int OP_BITS       = 2;
  localparam int AREA_BITS     = 20;
  localparam int GAIN_BITS     = 7;
  localparam int BAND_BITS     = 9;
  localparam int CMD_BITS      = 3;
  localparam int PHASE_BITS    = 2;
  localparam int PITCH_BITS    = 7;
  localparam int SCMD_BITS     = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = AREA_BITS;

  // Stabilize hold-off
  localparam int STABILIZE_TICKS = 20;
  localparam int CNT_BITS        = $clog2(STABILIZE_TICKS + 1);

  // Datapath widths
  localparam int CMP_BITS      = COORD_BITS + 2;
  localparam int YAW_PROD_BITS = GAIN_BITS + COORD_BITS;
  localparam int DIV_BITS      = GAIN_BITS + AREA_BITS;
  localparam int DVS_BITS      = AREA_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

  // Saturation limit of the steering commands
  localparam logic [PITCH_BITS-1:0] CMD_LIMIT = PITCH_BITS'(100);

  // Request codes
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_START  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CANCEL = 2'd2;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_LEFT    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_RIGHT   = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_STEER   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_TAKEOFF = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_SILENT  = 3'd5;

  // Phase codes
  localparam logic [PHASE_BITS-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_BITS-1:0] PH_STAB   = 2'd1;
  localparam logic [PHASE_BITS-1:0] PH_INIT   = 2'd2;
  localparam logic [PHASE_BITS-1:0] PH_SEARCH = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_SPAN     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDE_BAND     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NARROW_BAND   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_YAW_GAIN      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_GAIN    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTICAL_GAIN = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_AREA_REF      = 3'd7;

  // Controller to datapath commands
  typedef struct packed {
    logic                  load;
    logic                  start_yaw;
    logic                  start_pitch;
    logic                  capture_yaw;
    logic                  write_out;
    logic [CMD_BITS-1:0]   code;
    logic                  following;
    logic [PHASE_BITS-1:0] phase;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               seen;
    logic               left_out;
    logic               right_out;
    logic               in_narrow;
    logic               area_zero;
    logic               div_busy;
  } dp_stat_t;

endpackage

// ===== design/vtf_if.sv =====
// Channel interfaces: input ticks, result items and configuration writes.
// Depends on vtf_pkg for field widths.
interface vtf_item_if;
  logic                            valid;
  logic                            ready;
  logic [vtf_pkg::OP_BITS-1:0]     op;
  logic                            target_seen;
  logic [vtf_pkg::COORD_BITS-1:0]  target_x;
  logic [vtf_pkg::AREA_BITS-1:0]   target_area;

  modport source (output valid, op, target_seen, target_x, target_area, input ready);
  modport sink   (input valid, op, target_seen, target_x, target_area, output ready);
endinterface

interface vtf_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [vtf_pkg::CMD_BITS-1:0]         command;
  logic                                 move_flag;
  logic [vtf_pkg::PITCH_BITS-1:0]       pitch_cmd;
  logic signed [vtf_pkg::SCMD_BITS-1:0] yaw_cmd;
  logic signed [vtf_pkg::SCMD_BITS-1:0] vertical_cmd;
  logic                                 following;
  logic [vtf_pkg::PHASE_BITS-1:0]       phase;

  modport source (output valid, command, move_flag, pitch_cmd, yaw_cmd, vertical_cmd,
                  following, phase, input ready);
  modport sink   (input valid, command, move_flag, pitch_cmd, yaw_cmd, vertical_cmd,
                  following, phase, output ready);
endinterface

interface vtf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [vtf_pkg::CFG_IDX_BITS-1:0]    index;
  logic [vtf_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/visual_target_follow_controller_core.sv =====
// Visual target follow controller top level; uses vtf_pkg, vtf_if, vtf_ctrl, vtf_dp.
// A tick is captured, evaluated and written to the result register. Steering ticks use the
// shared restoring divider, one quotient bit per cycle: 17 yaw bits, then 27 pitch bits
// inside the narrow band with nonzero area. One tick is in flight at a time, the next taken
// only after the last result is written; a waiting result does not block the next tick.
// Synchronous reset restores the default configuration, following off, phase idle.
module visual_target_follow_controller_core (
  input logic          clk,
  input logic          rst,
  vtf_item_if.sink     item,
  vtf_result_if.source result,
  vtf_cfg_if.sink      cfg
);

  vtf_pkg::dp_cmd_t  dp_cmd;
  vtf_pkg::dp_stat_t dp_stat;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  vtf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  vtf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .in_op        (item.op),
    .in_seen      (item.target_seen),
    .in_x         (item.target_x),
    .in_area      (item.target_area),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .command      (result.command),
    .move_flag    (result.move_flag),
    .pitch_cmd    (result.pitch_cmd),
    .yaw_cmd      (result.yaw_cmd),
    .vertical_cmd (result.vertical_cmd),
    .following    (result.following),
    .phase        (result.phase)
  );

  // One tick in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("input taken while a tick is in flight");

  // Takeoff reports following in stabilize
  a_takeoff_state: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.command == vtf_pkg::CMD_TAKEOFF |->
      result.following && result.phase == vtf_pkg::PH_STAB)
    else $error("takeoff result with wrong state");

  // Steering only in search, with yaw inside the saturation range
  a_steer_state: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.command == vtf_pkg::CMD_STEER |->
      result.following && result.phase == vtf_pkg::PH_SEARCH &&
      result.yaw_cmd <= 8'sd100 && result.yaw_cmd >= -8'sd100)
    else $error("steer result out of range or in wrong phase");

  // Non-steering results carry zero steering fields
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.command != vtf_pkg::CMD_STEER |->
      !result.move_flag && result.pitch_cmd == '0 &&
      result.yaw_cmd == '0 && result.vertical_cmd == '0)
    else $error("steering fields set on a non-steering result");

endmodule

// ===== design/vtf_dp.sv =====
// Datapath: configuration registers, input capture, band compares,
// the shared restoring divider and the result register. Depends on vtf_pkg.
module vtf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vtf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [vtf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [vtf_pkg::OP_BITS-1:0]          in_op,
  input  logic                                 in_seen,
  input  logic [vtf_pkg::COORD_BITS-1:0]       in_x,
  input  logic [vtf_pkg::AREA_BITS-1:0]        in_area,
  input  vtf_pkg::dp_cmd_t                     cmd,
  output vtf_pkg::dp_stat_t                    stat,
  output logic [vtf_pkg::CMD_BITS-1:0]         command,
  output logic                                 move_flag,
  output logic [vtf_pkg::PITCH_BITS-1:0]       pitch_cmd,
  output logic signed [vtf_pkg::SCMD_BITS-1:0] yaw_cmd,
  output logic signed [vtf_pkg::SCMD_BITS-1:0] vertical_cmd,
  output logic                                 following,
  output logic [vtf_pkg::PHASE_BITS-1:0]       phase
);

  // Configuration registers
  logic [vtf_pkg::COORD_BITS-1:0] center_x;
  logic [vtf_pkg::COORD_BITS-1:0] half_span;
  logic [vtf_pkg::BAND_BITS-1:0]  wide_band;
  logic [vtf_pkg::BAND_BITS-1:0]  narrow_band;
  logic [vtf_pkg::GAIN_BITS-1:0]  yaw_gain;
  logic [vtf_pkg::GAIN_BITS-1:0]  speed_gain;
  logic [vtf_pkg::GAIN_BITS-1:0]  vertical_gain;
  logic [vtf_pkg::AREA_BITS-1:0]  area_ref;

  // Captured input
  logic [vtf_pkg::OP_BITS-1:0]    op_r;
  logic                           seen_r;
  logic [vtf_pkg::COORD_BITS-1:0] x_r;
  logic [vtf_pkg::AREA_BITS-1:0]  area_r;

  // Divider
  logic [vtf_pkg::DIV_BITS-1:0]     div_q;
  logic [vtf_pkg::DVS_BITS:0]       div_r;
  logic [vtf_pkg::DVS_BITS-1:0]     div_d;
  logic [vtf_pkg::DIV_CNT_BITS-1:0] div_cnt;
  logic [vtf_pkg::DVS_BITS:0]       rem_shift;
  logic                             rem_ge;

  // Steering values
  logic [vtf_pkg::PITCH_BITS-1:0]    yaw_mag;
  logic                              yaw_neg;
  logic [vtf_pkg::CMP_BITS-1:0]      x_ext;
  logic [vtf_pkg::CMP_BITS-1:0]      cx_ext;
  logic [vtf_pkg::CMP_BITS-1:0]      wb_ext;
  logic [vtf_pkg::CMP_BITS-1:0]      nb_ext;
  logic                              err_neg;
  logic [vtf_pkg::COORD_BITS-1:0]    err_mag;
  logic [vtf_pkg::YAW_PROD_BITS-1:0] yaw_prod;
  logic [vtf_pkg::DIV_BITS-1:0]      pitch_prod;
  logic [vtf_pkg::DVS_BITS-1:0]      yaw_divisor;
  logic [vtf_pkg::YAW_PROD_BITS-1:0] yaw_quot;
  logic [vtf_pkg::PITCH_BITS-1:0]    yaw_sat;
  logic [vtf_pkg::PITCH_BITS-1:0]    pitch_val;
  logic [vtf_pkg::SCMD_BITS-1:0]     yaw_val;
  logic [vtf_pkg::SCMD_BITS-1:0]     vert_val;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= vtf_pkg::COORD_BITS'(300);
      half_span     <= vtf_pkg::COORD_BITS'(300);
      wide_band     <= vtf_pkg::BAND_BITS'(100);
      narrow_band   <= vtf_pkg::BAND_BITS'(60);
      yaw_gain      <= vtf_pkg::GAIN_BITS'(70);
      speed_gain    <= vtf_pkg::GAIN_BITS'(50);
      vertical_gain <= vtf_pkg::GAIN_BITS'(10);
      area_ref      <= vtf_pkg::AREA_BITS'(3600);
    end else if (cfg_we) begin
      case (cfg_index)
        vtf_pkg::REG_CENTER_X:      center_x      <= cfg_data[vtf_pkg::COORD_BITS-1:0];
        vtf_pkg::REG_HALF_SPAN:     half_span     <= cfg_data[vtf_pkg::COORD_BITS-1:0];
        vtf_pkg::REG_WIDE_BAND:     wide_band     <= cfg_data[vtf_pkg::BAND_BITS-1:0];
        vtf_pkg::REG_NARROW_BAND:   narrow_band   <= cfg_data[vtf_pkg::BAND_BITS-1:0];
        vtf_pkg::REG_YAW_GAIN:      yaw_gain      <= cfg_data[vtf_pkg::GAIN_BITS-1:0];
        vtf_pkg::REG_SPEED_GAIN:    speed_gain    <= cfg_data[vtf_pkg::GAIN_BITS-1:0];
        vtf_pkg::REG_VERTICAL_GAIN: vertical_gain <= cfg_data[vtf_pkg::GAIN_BITS-1:0];
        vtf_pkg::REG_AREA_REF:      area_ref      <= cfg_data[vtf_pkg::AREA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted tick
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      seen_r <= in_seen;
      x_r    <= in_x;
      area_r <= in_area;
    end
  end

  // Band compares, done on non-negative sums so nothing wraps
  assign x_ext  = vtf_pkg::CMP_BITS'(x_r);
  assign cx_ext = vtf_pkg::CMP_BITS'(center_x);
  assign wb_ext = vtf_pkg::CMP_BITS'(wide_band);
  assign nb_ext = vtf_pkg::CMP_BITS'(narrow_band);

  assign stat.op        = op_r;
  assign stat.seen      = seen_r;
  assign stat.left_out  = (x_ext + wb_ext) < cx_ext;
  assign stat.right_out = x_ext > (cx_ext + wb_ext);
  assign stat.in_narrow = ((x_ext + nb_ext) > cx_ext) && (x_ext < (cx_ext + nb_ext));
  assign stat.area_zero = (area_r == '0);
  assign stat.div_busy  = (div_cnt != '0);

  // Error magnitude and dividends
  assign err_neg     = x_r < center_x;
  assign err_mag     = err_neg ? (center_x - x_r) : (x_r - center_x);
  assign yaw_prod    = vtf_pkg::YAW_PROD_BITS'(yaw_gain) *
                       vtf_pkg::YAW_PROD_BITS'(err_mag);
  assign pitch_prod  = vtf_pkg::DIV_BITS'(speed_gain) * vtf_pkg::DIV_BITS'(area_ref);
  assign yaw_divisor = (half_span == '0) ? vtf_pkg::DVS_BITS'(1)
                                         : vtf_pkg::DVS_BITS'(half_span);

  // One quotient bit per cycle
  assign rem_shift = {div_r[vtf_pkg::DVS_BITS-1:0], div_q[vtf_pkg::DIV_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start_yaw) begin
      div_q   <= {yaw_prod, {(vtf_pkg::DIV_BITS - vtf_pkg::YAW_PROD_BITS){1'b0}}};
      div_r   <= '0;
      div_d   <= yaw_divisor;
      div_cnt <= vtf_pkg::DIV_CNT_BITS'(vtf_pkg::YAW_PROD_BITS);
    end else if (cmd.start_pitch) begin
      div_q   <= pitch_prod;
      div_r   <= '0;
      div_d   <= area_r;
      div_cnt <= vtf_pkg::DIV_CNT_BITS'(vtf_pkg::DIV_BITS);
    end else if (div_cnt != '0) begin
      div_q   <= {div_q[vtf_pkg::DIV_BITS-2:0], rem_ge};
      div_r   <= rem_ge ? (rem_shift - {1'b0, div_d}) : rem_shift;
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Saturate and hold the yaw result before the divider is reused
  assign yaw_quot = div_q[vtf_pkg::YAW_PROD_BITS-1:0];
  assign yaw_sat  = (yaw_quot > vtf_pkg::YAW_PROD_BITS'(vtf_pkg::CMD_LIMIT))
                    ? vtf_pkg::CMD_LIMIT : yaw_quot[vtf_pkg::PITCH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture_yaw) begin
      yaw_mag <= yaw_sat;
      yaw_neg <= err_neg && (yaw_sat != '0);
    end
  end

  // Pitch: zero outside the narrow band; inside it, full gain for zero area, else capped quotient
  always_comb begin
    if (!stat.in_narrow) begin
      pitch_val = '0;
    end else if (stat.area_zero) begin
      pitch_val = speed_gain;
    end else if (div_q > vtf_pkg::DIV_BITS'(speed_gain)) begin
      pitch_val = speed_gain;
    end else begin
      pitch_val = div_q[vtf_pkg::PITCH_BITS-1:0];
    end
  end

  assign yaw_val  = yaw_neg ? (vtf_pkg::SCMD_BITS'(0) - vtf_pkg::SCMD_BITS'(yaw_mag))
                            : vtf_pkg::SCMD_BITS'(yaw_mag);
  assign vert_val = yaw_neg ? vtf_pkg::SCMD_BITS'(vertical_gain)
                            : (vtf_pkg::SCMD_BITS'(0) - vtf_pkg::SCMD_BITS'(vertical_gain));

  // Result register; steering fields are zero unless steering
  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      command   <= cmd.code;
      following <= cmd.following;
      phase     <= cmd.phase;
      if (cmd.code == vtf_pkg::CMD_STEER) begin
        move_flag    <= (pitch_val != '0);
        pitch_cmd    <= pitch_val;
        yaw_cmd      <= yaw_val;
        vertical_cmd <= vert_val;
      end else begin
        move_flag    <= 1'b0;
        pitch_cmd    <= '0;
        yaw_cmd      <= '0;
        vertical_cmd <= '0;
      end
    end
  end

endmodule

// ===== design/vtf_ctrl.sv =====
// Controller: tick sequencing, follow/phase/stabilize state and result handshake.
// Depends on vtf_pkg; drives the datapath through dp_cmd_t.
module vtf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vtf_pkg::dp_stat_t stat,
  output vtf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_YAW    = 5'b00100,
    S_PITCH  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic                            follow_on, follow_on_next;
  logic [vtf_pkg::PHASE_BITS-1:0]  phase_reg, phase_reg_next;
  logic [vtf_pkg::CNT_BITS-1:0]    stab_count, stab_count_next;
  logic [vtf_pkg::CMD_BITS-1:0]    res_cmd, res_cmd_next;
  logic [vtf_pkg::PHASE_BITS-1:0]  eff_phase;
  logic [vtf_pkg::CNT_BITS:0]      count_inc;

  assign item_ready = (state == S_IDLE);
  assign eff_phase  = stat.seen ? phase_reg : vtf_pkg::PH_INIT;
  assign count_inc  = {1'b0, stab_count} + 1'b1;

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    follow_on_next  = follow_on;
    phase_reg_next  = phase_reg;
    stab_count_next = stab_count;
    res_cmd_next    = res_cmd;
    cmd             = '0;
    cmd.code        = res_cmd;
    cmd.following   = follow_on;
    cmd.phase       = phase_reg;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_RESULT;
        if (stat.op == vtf_pkg::OP_START) begin
          follow_on_next  = 1'b1;
          phase_reg_next  = vtf_pkg::PH_STAB;
          stab_count_next = '0;
          res_cmd_next    = vtf_pkg::CMD_TAKEOFF;
        end else if (stat.op == vtf_pkg::OP_CANCEL) begin
          follow_on_next = 1'b0;
          res_cmd_next   = vtf_pkg::CMD_SILENT;
        end else if (!follow_on) begin
          res_cmd_next = vtf_pkg::CMD_NONE;
        end else begin
          // a missing target drops back to initial search first
          phase_reg_next = eff_phase;
          case (eff_phase)
            vtf_pkg::PH_STAB: begin
              res_cmd_next = vtf_pkg::CMD_NONE;
              if (count_inc > (vtf_pkg::CNT_BITS + 1)'(vtf_pkg::STABILIZE_TICKS)) begin
                phase_reg_next  = vtf_pkg::PH_INIT;
                stab_count_next = '0;
              end else begin
                stab_count_next = count_inc[vtf_pkg::CNT_BITS-1:0];
              end
            end
            vtf_pkg::PH_INIT: begin
              if (!stat.seen) begin
                res_cmd_next = vtf_pkg::CMD_RIGHT;
              end else if (stat.left_out) begin
                res_cmd_next = vtf_pkg::CMD_LEFT;
              end else if (stat.right_out) begin
                res_cmd_next = vtf_pkg::CMD_RIGHT;
              end else begin
                phase_reg_next  = vtf_pkg::PH_SEARCH;
                stab_count_next = '0;
                res_cmd_next    = vtf_pkg::CMD_SILENT;
              end
            end
            vtf_pkg::PH_SEARCH: begin
              res_cmd_next  = vtf_pkg::CMD_STEER;
              cmd.start_yaw = 1'b1;
              state_next    = S_YAW;
            end
            default: begin
              res_cmd_next = vtf_pkg::CMD_NONE;
            end
          endcase
        end
      end
      S_YAW: begin
        if (!stat.div_busy) begin
          cmd.capture_yaw = 1'b1;
          if (stat.in_narrow && !stat.area_zero) begin
            cmd.start_pitch = 1'b1;
            state_next      = S_PITCH;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_PITCH: begin
        if (!stat.div_busy) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        // write once the output register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      follow_on  <= 1'b0;
      phase_reg  <= vtf_pkg::PH_IDLE;
      stab_count <= '0;
      res_cmd    <= vtf_pkg::CMD_NONE;
    end else begin
      state      <= state_next;
      follow_on  <= follow_on_next;
      phase_reg  <= phase_reg_next;
      stab_count <= stab_count_next;
      res_cmd    <= res_cmd_next;
    end
  end

  // Output valid: set on write, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
